>>> rtl/cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int SCORE_BITS = 40;
  localparam int BUDGET_W   = 56;
  localparam int SUM_W      = BUDGET_W + 1;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef struct packed {
    logic   start;
    score_t level;
    count_t count;
  } pass_req_t;

  typedef struct packed {
    logic done;
    sum_t sum;
  } pass_rsp_t;

endpackage

`default_nettype wire

>>> rtl/cts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/cts_excess.sv
`timescale 1ns / 1ps
`default_nettype none

module cts_excess (
  input  logic                         clk,
  input  logic                         rst,
  input  cts_pkg::pass_req_t           req,
  input  logic [cts_pkg::BUDGET_W-1:0] budget,
  output logic                         rd_en,
  output logic [cts_pkg::ADDR_W-1:0]   rd_addr,
  input  cts_pkg::score_t              rd_data,
  output cts_pkg::pass_rsp_t           rsp
);

  import cts_pkg::*;

  logic   busy;
  count_t idx;
  count_t count;
  score_t level;
  logic   rd_v;
  logic   d_v;
  score_t diff;
  sum_t   acc;
  sum_t   cap;
  sum_t   acc_add;
  logic   issue;

  assign cap     = {1'b0, budget} + sum_t'(1);
  assign issue   = busy && (idx != count);
  assign rd_en   = issue;
  assign rd_addr = idx[ADDR_W-1:0];
  assign acc_add = acc + sum_t'(diff);

  assign rsp.done = busy && !issue && !rd_v && !d_v;
  assign rsp.sum  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd_v <= 1'b0;
      d_v  <= 1'b0;
    end else begin
      rd_v <= issue;
      d_v  <= rd_v;
      if (req.start) begin
        busy <= 1'b1;
      end else if (rsp.done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      idx   <= '0;
      count <= req.count;
      level <= req.level;
      acc   <= '0;
    end else begin
      if (issue) begin
        idx <= idx + count_t'(1);
      end
      if (d_v) begin
        acc <= (acc_add > cap) ? cap : acc_add;
      end
    end
    diff <= (rd_data > level) ? (rd_data - level) : '0;
  end

  // running sum saturates at one above the budget
  a_acc_capped: assert property (@(posedge clk) disable iff (rst)
    busy |-> acc <= cap)
    else $error("excess sum above cap");

  // reads never run past the loaded count
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= count)
    else $error("read index past count");

endmodule

`default_nettype wire

>>> rtl/clip_threshold_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | signals                              | contents
// s_axis   | in  | tvalid tready tdata[39:0] tlast      | tdata: score; tlast: last_item
// m_axis   | out | tvalid tready tdata[39:0] tuser[0:0] | tdata: clip_level; tuser: overflowed
// budget   | in  | budget_wr_en budget_wr_data[55:0]    | budget register write
//
// loading: one score beat per cycle into the score memory
// search: up to 40 bisection passes, each reading all n stored scores in turn
//   through the single read port of the score memory into the excess adder
// the result sits in an output register; loading of the next set goes on meanwhile
// rst is synchronous; no clearing pass, the memory is only read where written

module clip_threshold_search_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,   // score
  input  logic                         s_axis_tlast,   // last_item
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [39:0]                  m_axis_tdata,   // clip_level
  output logic [0:0]                   m_axis_tuser,   // overflowed
  input  logic                         budget_wr_en,
  input  logic [cts_pkg::BUDGET_W-1:0] budget_wr_data
);

  import cts_pkg::*;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_MID  = 3'd1;
  localparam logic [2:0] ST_PASS = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0]          state;
  logic [BUDGET_W-1:0] budget;
  count_t              count;
  score_t              largest;
  logic                ovf;
  score_t              low;
  score_t              high;
  score_t              mid;
  score_t              score_in;
  logic                in_beat;
  logic                store_ok;
  logic                emit_go;
  score_t              largest_next;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_addr;
  score_t              ram_rd_data;
  pass_req_t           req;
  pass_rsp_t           rsp;

  assign s_axis_tready = (state == ST_LOAD);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign score_in      = s_axis_tdata[SCORE_BITS-1:0];
  assign store_ok      = (count < count_t'(MAX_ITEMS));
  assign largest_next  = (store_ok && score_in > largest) ? score_in : largest;
  assign emit_go       = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  assign req.start = (state == ST_MID) && (low < high);
  assign req.level = low + ((high - low) >> 1);
  assign req.count = count;

  cts_ram #(
    .WIDTH(SCORE_BITS),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk    (clk),
    .wr_en  (in_beat && store_ok),
    .wr_addr(count[ADDR_W-1:0]),
    .wr_data(score_in),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  cts_excess u_excess (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .budget (budget),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data),
    .rsp    (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (budget_wr_en) begin
      budget <= budget_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      largest       <= '0;
      ovf           <= 1'b0;
      low           <= '0;
      high          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_beat) begin
            largest <= largest_next;
            if (store_ok) begin
              count <= count + count_t'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_axis_tlast) begin
              low   <= '0;
              high  <= largest_next;
              state <= ST_MID;
            end
          end
        end
        ST_MID: begin
          if (low < high) begin
            mid   <= req.level;
            state <= ST_PASS;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_PASS: begin
          if (rsp.done) begin
            if (rsp.sum > {1'b0, budget}) begin
              low <= mid + score_t'(1);
            end else begin
              high <= mid;
            end
            state <= ST_MID;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            m_axis_tdata  <= low;
            m_axis_tuser  <= ovf;
            count         <= '0;
            largest       <= '0;
            ovf           <= 1'b0;
            state         <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MID || state == ST_PASS) |-> low <= high)
    else $error("search range inverted");

  a_mid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS) |-> (mid >= low && mid < high))
    else $error("midpoint outside range");

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(MAX_ITEMS))
    else $error("item count past capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) |=>
      (count == '0 && !ovf && m_axis_tvalid))
    else $error("set not cleared after result");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  cts_pkg::score_t level;
  logic            ovf;
} clip_result_t;

class clip_scoreboard;
  logic [cts_pkg::BUDGET_W-1:0] budget;
  cts_pkg::score_t              scores [cts_pkg::MAX_ITEMS];
  int unsigned                  n_scores;
  cts_pkg::score_t              peak;
  logic                         dropped;
  clip_result_t                 levels_due [$];
  int unsigned                  errors;

  function new();
    budget   = '0;
    n_scores = 0;
    peak     = '0;
    dropped  = 1'b0;
    errors   = 0;
  endfunction

  // total excess above a level, saturated one past the budget
  function logic [63:0] excess_at(cts_pkg::score_t lvl);
    logic [63:0] cap;
    logic [63:0] acc;
    cap = 64'(budget) + 64'd1;
    acc = '0;
    for (int unsigned i = 0; i < n_scores; i++) begin
      if (scores[i] > lvl) begin
        acc += 64'(scores[i] - lvl);
        if (acc > cap) acc = cap;
      end
    end
    return acc;
  endfunction

  function void note_score(cts_pkg::score_t s, logic last);
    cts_pkg::score_t lo;
    cts_pkg::score_t hi;
    cts_pkg::score_t mid;
    clip_result_t    r;
    if (n_scores < cts_pkg::MAX_ITEMS) begin
      scores[n_scores] = s;
      n_scores++;
      if (s > peak) peak = s;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    lo = '0;
    hi = peak;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (excess_at(mid) > 64'(budget)) lo = mid + 1;
      else hi = mid;
    end
    r.level = lo;
    r.ovf   = dropped;
    levels_due.push_back(r);
    n_scores = 0;
    peak     = '0;
    dropped  = 1'b0;
  endfunction

  function void check_clip(cts_pkg::score_t lvl, logic ovf);
    clip_result_t e;
    if (levels_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual clip_level %h overflowed %b",
               $time, lvl, ovf);
      errors++;
      return;
    end
    e = levels_due.pop_front();
    if (lvl !== e.level) begin
      $display("%0t: clip_level expected %h actual %h", $time, e.level, lvl);
      errors++;
    end
    if (ovf !== e.ovf) begin
      $display("%0t: overflowed expected %b actual %b", $time, e.ovf, ovf);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return levels_due.size();
  endfunction
endclass

module tb;
  import cts_pkg::*;

  localparam int unsigned LIMIT    = 200000;
  localparam int unsigned QUIET    = 64;
  localparam int unsigned PHASES   = 12;
  localparam int unsigned N_RANDOM = 300;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata;   // score
  logic                s_axis_tlast;   // last_item
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;   // clip_level
  logic [0:0]          m_axis_tuser;   // overflowed
  logic                budget_wr_en;
  logic [BUDGET_W-1:0] budget_wr_data;

  int unsigned    send_idle    = 0;
  int unsigned    recv_stall   = 0;
  int unsigned    quiet_cycles = 0;
  clip_scoreboard sb;

  clip_threshold_search_unit uut (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .budget_wr_en   (budget_wr_en),
    .budget_wr_data (budget_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_score(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_clip(m_axis_tdata, m_axis_tuser[0]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= LIMIT) begin
        $display("FAIL clip_threshold_search_unit");
        $finish;
      end
    end
  end

  task automatic send_score(input score_t sc, input logic lst);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sc;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
  endtask

  function automatic score_t pick_score(input int unsigned bits);
    score_t r;
    r = score_t'({$urandom, $urandom});
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return r & ((score_t'(1) << bits) - score_t'(1));
    endcase
  endfunction

  function automatic logic [BUDGET_W-1:0] pick_budget(input int unsigned ph);
    logic [BUDGET_W-1:0] r;
    int unsigned         w;
    r = BUDGET_W'({$urandom, $urandom});
    w = $urandom_range(1, BUDGET_W);
    case (ph % 6)
      0:       return '0;
      3:       return '1;
      default: return r & ((BUDGET_W'(1) << w) - BUDGET_W'(1));
    endcase
  endfunction

  task automatic send_random_set(input int unsigned n, input int unsigned bits);
    for (int unsigned i = 0; i < n; i++) send_score(pick_score(bits), i == n - 1);
  endtask

  // wait for all pending levels, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] v);
    budget_wr_en   <= 1'b1;
    budget_wr_data <= v;
    @(posedge clk);
    budget_wr_en <= 1'b0;
    sb.budget = v;
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    sb = new();
    rst            <= 1'b1;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tlast   <= 1'b0;
    budget_wr_en   <= 1'b0;
    budget_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero budget after reset: level is the peak score
    send_score('0, 1'b1);
    send_score('1, 1'b1);
    send_score(40'h55_5555_5555, 1'b0);
    send_score(40'haa_aaaa_aaaa, 1'b0);
    send_score('0, 1'b0);
    send_score('1, 1'b1);
    settle();
    write_budget('1);
    send_score('1, 1'b0);
    send_score('1, 1'b0);
    send_score(40'd7, 1'b1);
    settle();
    write_budget(56'd10);
    send_score(40'd20, 1'b0);
    send_score(40'd20, 1'b0);
    send_score(40'd20, 1'b1);
    settle();
    write_budget(56'd1);
    send_score('1, 1'b0);
    send_score('0, 1'b1);
    send_score(40'd5, 1'b1);
    for (int unsigned i = 0; i < 4; i++) send_score(40'd9, i == 3);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      settle();
      write_budget(pick_budget(ph));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      // a set that fills the store, then drops its last beats including the marked one
      if (ph == 10) send_random_set(MAX_ITEMS + 3, SCORE_BITS);
      sent = 0;
      while (sent < N_RANDOM / PHASES) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        send_random_set(n, $urandom_range(1, SCORE_BITS));
        sent += n;
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS clip_threshold_search_unit");
    end else begin
      $display("FAIL clip_threshold_search_unit");
    end
    $finish;
  end
endmodule
